/* hw/rtl/dksf_pkg.sv */
// Package for the debounced key scanner: item kinds, register map, FIFO sizing,
// and the command bundle passed from controller to datapath. No dependencies.
package dksf_pkg;

   // FIFO geometry
   localparam int FifoDepth  = 16;
   localparam int PtrWidth   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CountWidth = $clog2(FifoDepth + 1);

   // Field widths
   localparam int CodeWidth     = 8;
   localparam int KeyCountWidth = 5;
   localparam int HeldWidth     = 16;
   localparam int CsrDataWidth  = 32;
   localparam int CsrAddrWidth  = 3;

   // Register reset values
   localparam logic [7:0] ScanStepReset      = 8'd10;
   localparam logic [7:0] BacklightTimeReset = 8'd30;

   // Register indexes (word address)
   localparam logic REG_SCAN_STEP      = 1'b0;
   localparam logic REG_BACKLIGHT_TIME = 1'b1;

   typedef enum logic [1:0] {
      KIND_SCAN       = 2'd0,
      KIND_POP        = 2'd1,
      KIND_CLEAR_BUF  = 2'd2,
      KIND_CLEAR_TIME = 2'd3
   } kind_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic capture;     // latch the accepted item
      logic execute;     // apply the item to state, pop read
      logic load_front;  // read the FIFO head into the result
   } ctrl_cmd_type;

endpackage

/* hw/rtl/dksf_ctrl.sv */
// Controller state machine for the key scanner: sequences capture, execute,
// head read and result transfer. Depends on dksf_pkg.
module dksf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dksf_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_FRONT = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC:  state_in = ST_FRONT;
         ST_FRONT: state_in = ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign cmd.capture    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute    = (state_ff == ST_EXEC);
   assign cmd.load_front = (state_ff == ST_FRONT);

endmodule

/* hw/rtl/dksf_datapath.sv */
// Datapath for the key scanner: debouncer state, held-time counter, code FIFO
// memory and result registers. Depends on dksf_pkg.
module dksf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dksf_pkg::ctrl_cmd_type              cmd,
   input  logic [1:0]                          req_kind,
   input  logic [dksf_pkg::CodeWidth-1:0]      req_key_code,
   input  logic [7:0]                          scan_step,
   input  logic [7:0]                          backlight_time,
   output logic [dksf_pkg::CodeWidth-1:0]      rsp_popped_code,
   output logic [dksf_pkg::CodeWidth-1:0]      rsp_front_code,
   output logic [dksf_pkg::KeyCountWidth-1:0]  rsp_key_count,
   output logic                                rsp_key_hit,
   output logic [dksf_pkg::HeldWidth-1:0]      rsp_held_time,
   output logic                                rsp_key_down,
   output logic                                rsp_backlight_set,
   output logic [7:0]                          rsp_backlight_value
);

   localparam logic [dksf_pkg::PtrWidth-1:0] LastPtr =
      dksf_pkg::PtrWidth'(dksf_pkg::FifoDepth - 1);
   localparam logic [dksf_pkg::CountWidth-1:0] FullCount =
      dksf_pkg::CountWidth'(dksf_pkg::FifoDepth);

   // Latched item
   dksf_pkg::kind_type                kind_ff;
   logic [dksf_pkg::CodeWidth-1:0]    code_ff;

   // Scanner state
   logic                              phase_ff, phase_in;
   logic [dksf_pkg::CodeWidth-1:0]    last_ff, last_in;
   logic [dksf_pkg::PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dksf_pkg::PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dksf_pkg::CountWidth-1:0]   count_ff, count_in;
   logic [dksf_pkg::HeldWidth-1:0]    held_ff, held_in;
   logic                              flag_ff, flag_in;
   logic                              push;
   logic                              pop;

   // Result registers
   logic [dksf_pkg::CodeWidth-1:0]    popped_ff;
   logic [dksf_pkg::CodeWidth-1:0]    front_ff;
   logic                              bl_set_ff;
   logic [7:0]                        bl_value_ff;

   logic [dksf_pkg::CodeWidth-1:0]    mem [dksf_pkg::FifoDepth];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= dksf_pkg::kind_type'(req_kind);
         code_ff <= req_key_code;
      end
   end

   // Next-state for one item
   always_comb begin
      phase_in  = phase_ff;
      last_in   = last_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      flag_in   = flag_ff;
      push      = 1'b0;
      pop       = 1'b0;
      case (kind_ff)
         dksf_pkg::KIND_SCAN: begin
            if (!phase_ff) begin
               held_in = '0;
               if (code_ff != '0) begin
                  phase_in = 1'b1;
                  last_in  = '0;
               end
            end else if (code_ff != '0) begin
               if (code_ff != last_ff) begin
                  last_in = code_ff;
                  push    = (count_ff != FullCount);
               end
               held_in = held_ff + dksf_pkg::HeldWidth'(scan_step);
               flag_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               flag_in  = 1'b0;
            end
         end
         dksf_pkg::KIND_POP: begin
            pop = (count_ff != '0);
         end
         dksf_pkg::KIND_CLEAR_BUF: begin
            count_in  = '0;
            rd_ptr_in = wr_ptr_ff;
         end
         dksf_pkg::KIND_CLEAR_TIME: begin
            held_in = '0;
         end
         default: begin
            held_in = held_ff;
         end
      endcase
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         last_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         held_ff   <= '0;
         flag_ff   <= 1'b0;
      end else if (cmd.execute) begin
         phase_ff  <= phase_in;
         last_ff   <= last_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         held_ff   <= held_in;
         flag_ff   <= flag_in;
      end
   end

   // FIFO memory: one write port, reads at the read pointer only
   always_ff @(posedge clock) begin
      if (cmd.execute && push) begin
         mem[wr_ptr_ff] <= code_ff;
      end
      if (cmd.execute) begin
         popped_ff   <= pop ? mem[rd_ptr_ff] : '0;
         bl_set_ff   <= (kind_ff == dksf_pkg::KIND_SCAN) && (count_in != '0);
         bl_value_ff <= ((kind_ff == dksf_pkg::KIND_SCAN) && (count_in != '0))
                        ? backlight_time : '0;
      end
      if (cmd.load_front) begin
         front_ff <= (count_ff != '0) ? mem[rd_ptr_ff] : '0;
      end
   end

   assign rsp_popped_code     = popped_ff;
   assign rsp_front_code      = front_ff;
   assign rsp_key_count       = dksf_pkg::KeyCountWidth'(count_ff);
   assign rsp_key_hit         = (count_ff != '0);
   assign rsp_held_time       = held_ff;
   assign rsp_key_down        = flag_ff;
   assign rsp_backlight_set   = bl_set_ff;
   assign rsp_backlight_value = bl_value_ff;

endmodule

/* hw/rtl/debounced_key_scanner_fifo_core.sv */
// Top level of the debounced key scanner with code FIFO: configuration
// registers and the controller/datapath pair. Depends on dksf_pkg, dksf_ctrl, dksf_datapath.
//
// Each input transfer is one item: a scan tick with the sampled key code, a
// pop, a buffer clear or a held-time clear. Every item yields exactly one
// result transfer carrying the popped code, the FIFO head and count, the
// held time, the debounced key-down flag and the backlight request. The
// block works on one item at a time: an item accepted in IDLE is applied in
// the next cycle, the FIFO head is read from the code memory in the cycle
// after (single read port at the read pointer), and the result is offered
// in RESP until rsp_ready is high. Items follow the controller's four-state
// sequence IDLE, EXEC, FRONT, RESP. The 16-entry code memory needs no
// clearing pass after reset. Registers: scan_step at byte address 0,
// backlight_time at 4; write them only while the block is idle.
module debounced_key_scanner_fifo_core (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [dksf_pkg::CodeWidth-1:0]      req_key_code,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dksf_pkg::CodeWidth-1:0]      rsp_popped_code,
   output logic [dksf_pkg::CodeWidth-1:0]      rsp_front_code,
   output logic [dksf_pkg::KeyCountWidth-1:0]  rsp_key_count,
   output logic                                rsp_key_hit,
   output logic [dksf_pkg::HeldWidth-1:0]      rsp_held_time,
   output logic                                rsp_key_down,
   output logic                                rsp_backlight_set,
   output logic [7:0]                          rsp_backlight_value,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dksf_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [dksf_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [dksf_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready
);

   dksf_pkg::ctrl_cmd_type cmd;

   logic [7:0] scan_step_ff;
   logic [7:0] backlight_time_ff;
   logic       csr_wr;
   logic       reg_sel;

   // Word address select; byte offset bits are ignored
   assign reg_sel    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_step_ff      <= dksf_pkg::ScanStepReset;
         backlight_time_ff <= dksf_pkg::BacklightTimeReset;
      end else if (csr_wr) begin
         if (reg_sel == dksf_pkg::REG_SCAN_STEP) begin
            scan_step_ff <= csr_pwdata[7:0];
         end else begin
            backlight_time_ff <= csr_pwdata[7:0];
         end
      end
   end

   // Read back; both registers are 8 bits, zero extended
   always_comb begin
      case (reg_sel)
         dksf_pkg::REG_SCAN_STEP:
            csr_prdata = dksf_pkg::CsrDataWidth'(scan_step_ff);
         dksf_pkg::REG_BACKLIGHT_TIME:
            csr_prdata = dksf_pkg::CsrDataWidth'(backlight_time_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   dksf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dksf_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_kind            (req_kind),
      .req_key_code        (req_key_code),
      .scan_step           (scan_step_ff),
      .backlight_time      (backlight_time_ff),
      .rsp_popped_code     (rsp_popped_code),
      .rsp_front_code      (rsp_front_code),
      .rsp_key_count       (rsp_key_count),
      .rsp_key_hit         (rsp_key_hit),
      .rsp_held_time       (rsp_held_time),
      .rsp_key_down        (rsp_key_down),
      .rsp_backlight_set   (rsp_backlight_set),
      .rsp_backlight_value (rsp_backlight_value)
   );

endmodule
